// ----- design/gbn_pkg.sv -----
// gbn_pkg: shared types and codes for the go-back-n sender window
// used by gbn_ctrl, gbn_dpath and go_back_n_sender_window
`default_nettype none
package gbn_pkg;

  // input event codes
  localparam logic [1:0] OP_NEW     = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // result kinds
  typedef enum logic [2:0] {
    KIND_SEND   = 3'd0,
    KIND_TSTART = 3'd1,
    KIND_TSTOP  = 3'd2,
    KIND_OVER   = 3'd3,
    KIND_BUILD  = 3'd4
  } kind_e;

  localparam int unsigned PREFIX_BYTES = 4;

  // one result word before packing
  typedef struct packed {
    kind_e       kind;
    logic [31:0] seq_number;
    logic [3:0]  window_slot;
    logic [7:0]  payload_length;
    logic [15:0] message_offset;
    logic        message_end;
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic push;
    logic rewind;
    logic tstart;
    logic slide;
    logic build;
    logic send_init;
    logic send;
    logic tstop;
    logic overflow;
    logic flush;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic timer_on;
    logic in_win;
    logic build_ok;
    logic send_ok;
    logic stop_hit;
    logic can_emit;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- design/gbn_ctrl.sv -----
// gbn_ctrl: event sequencer of the go-back-n sender window
// depends on gbn_pkg for command and status structs
`default_nettype none
module gbn_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        in_op_i,
  input  wire logic              in_ck_i,
  output logic                   in_ready_o,
  input  wire gbn_pkg::dp_stat_t stat_i,
  output gbn_pkg::dp_cmd_t       cmd_o
);
  import gbn_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_OVF  = 4'd1;
  localparam logic [3:0] S_RWD  = 4'd2;
  localparam logic [3:0] S_TST  = 4'd3;
  localparam logic [3:0] S_ACMP = 4'd4;
  localparam logic [3:0] S_AWIN = 4'd5;
  localparam logic [3:0] S_BCHK = 4'd6;
  localparam logic [3:0] S_BLD  = 4'd7;
  localparam logic [3:0] S_SSET = 4'd8;
  localparam logic [3:0] S_SND  = 4'd9;
  localparam logic [3:0] S_ASTP = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0] state_q, state_d;
  logic       ack_q, ack_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    ack_d   = ack_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.latch = 1'b1;
          ack_d       = 1'b0;
          unique case (in_op_i)
            OP_NEW: begin
              if (stat_i.full) begin
                state_d = S_OVF;
              end else begin
                cmd_o.push = 1'b1;
                state_d    = stat_i.timer_on ? S_FIN : S_TST;
              end
            end
            OP_ACK: begin
              ack_d   = 1'b1;
              state_d = in_ck_i ? S_ACMP : S_FIN;
            end
            OP_TIMEOUT: state_d = S_RWD;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_OVF: begin
        if (stat_i.can_emit) begin
          cmd_o.overflow = 1'b1;
          state_d        = S_FIN;
        end
      end
      S_RWD: begin
        cmd_o.rewind = 1'b1;
        state_d      = S_TST;
      end
      S_TST: begin
        if (stat_i.can_emit) begin
          cmd_o.tstart = 1'b1;
          state_d      = S_BCHK;
        end
      end
      S_ACMP: state_d = stat_i.in_win ? S_AWIN : S_ASTP;
      S_AWIN: begin
        if (stat_i.can_emit) begin
          cmd_o.tstart = 1'b1;
          cmd_o.slide  = 1'b1;
          state_d      = S_BCHK;
        end
      end
      S_BCHK: state_d = stat_i.build_ok ? S_BLD : S_SSET;
      S_BLD: begin
        if (stat_i.can_emit) begin
          cmd_o.build = 1'b1;
          state_d     = S_BCHK;
        end
      end
      S_SSET: begin
        cmd_o.send_init = 1'b1;
        state_d         = S_SND;
      end
      S_SND: begin
        if (!stat_i.send_ok) begin
          state_d = ack_q ? S_ASTP : S_FIN;
        end else if (stat_i.can_emit) begin
          cmd_o.send = 1'b1;
        end
      end
      S_ASTP: begin
        if (!stat_i.stop_hit) begin
          state_d = S_FIN;
        end else if (stat_i.can_emit) begin
          cmd_o.tstop = 1'b1;
          state_d     = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.can_emit) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ack_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ack_q   <= ack_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/gbn_dpath.sv -----
// gbn_dpath: window counters, message length queue and result buffering
// depends on gbn_pkg for result, command and status types
`default_nettype none
module gbn_dpath #(
  parameter int unsigned WINDOW      = 10,
  parameter int unsigned PAYLOAD_MAX = 121,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire gbn_pkg::dp_cmd_t cmd_i,
  input  wire logic [15:0]      size_i,
  input  wire logic [31:0]      ack_i,
  output gbn_pkg::dp_stat_t     stat_o,
  output gbn_pkg::res_t         out_res_o,
  output logic                  out_last_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i
);
  import gbn_pkg::*;

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned FW  = $clog2(WINDOW + 1);
  localparam logic [QAW-1:0] QLAST = QAW'(QUEUE_DEPTH - 1);
  localparam logic [QCW-1:0] QFULL = QCW'(QUEUE_DEPTH);
  localparam logic [FW-1:0]  WFILL = FW'(WINDOW);
  localparam logic [3:0]     WMLAST = 4'(WINDOW - 1);
  localparam logic [31:0]    W32 = 32'(WINDOW);
  localparam logic [15:0]    PM16 = 16'(PAYLOAD_MAX);

  // queue storage
  logic [15:0]    mem_q [QUEUE_DEPTH];
  logic [15:0]    rd_q;
  logic [QAW-1:0] head_q, tail_q;
  logic [QCW-1:0] count_q;

  // window state
  logic [15:0] off_q;
  logic [31:0] nns_q, nts_q, old_q, lo_q, ack_q;
  logic [3:0]  nns_m_q, nts_m_q, old_m_q;
  logic [FW-1:0] fill_q;
  logic [FW-1:0] guard_q;
  logic        timer_q;

  // result buffering
  res_t pend_q, out_q;
  logic pend_v_q, out_v_q, last_q;

  logic [15:0] rem;
  logic [31:0] d;
  logic [5:0]  msum;
  logic        emit_v;
  res_t        emit_r;
  logic        out_free;

  function automatic logic [3:0] mod_inc(input logic [3:0] m);
    mod_inc = (m == WMLAST) ? 4'd0 : m + 4'd1;
  endfunction

  function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
    ptr_inc = (p == QLAST) ? '0 : p + 1'b1;
  endfunction

  // remaining bytes of head message and ack slide distance
  assign rem  = (rd_q > off_q) ? rd_q - off_q : 16'd0;
  assign d    = ack_q - old_q + 32'd1;
  assign msum = {2'b00, old_m_q} + {1'b0, d[4:0]};

  assign out_free = !out_v_q || out_ready_i;

  // status
  assign stat_o.full     = (count_q >= QFULL);
  assign stat_o.timer_on = timer_q;
  assign stat_o.in_win   = (ack_q >= old_q) && (ack_q < nns_q);
  assign stat_o.build_ok = (fill_q < WFILL) && (count_q != '0);
  assign stat_o.send_ok  = (nts_q >= lo_q) && (nts_q < nns_q) && (guard_q < WFILL);
  assign stat_o.stop_hit = (ack_q + 32'd1 == nns_q);
  assign stat_o.can_emit = !pend_v_q || out_free;

  // result produced this cycle
  always_comb begin
    emit_v = 1'b0;
    emit_r = '0;
    emit_r.kind = KIND_SEND;
    if (cmd_i.tstart) begin
      emit_v      = 1'b1;
      emit_r.kind = KIND_TSTART;
    end else if (cmd_i.tstop) begin
      emit_v      = 1'b1;
      emit_r.kind = KIND_TSTOP;
    end else if (cmd_i.overflow) begin
      emit_v      = 1'b1;
      emit_r.kind = KIND_OVER;
    end else if (cmd_i.send) begin
      emit_v             = 1'b1;
      emit_r.seq_number  = nts_q;
      emit_r.window_slot = nts_m_q;
    end else if (cmd_i.build && rem != 16'd0) begin
      emit_v                = 1'b1;
      emit_r.kind           = KIND_BUILD;
      emit_r.seq_number     = nns_q;
      emit_r.window_slot    = nns_m_q;
      emit_r.message_offset = off_q;
      if (rem > PM16) begin
        emit_r.payload_length = PM16[7:0];
      end else begin
        emit_r.payload_length = rem[7:0];
        emit_r.message_end    = 1'b1;
      end
    end
  end

  // queue memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[tail_q] <= size_i + 16'(PREFIX_BYTES);
    end
    rd_q <= mem_q[head_q];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      ack_q <= ack_i;
    end
    if (cmd_i.send_init) begin
      lo_q <= (nns_q >= W32) ? nns_q - W32 : 32'd0;
    end
    if (emit_v) begin
      pend_q <= emit_r;
      if (pend_v_q) begin
        out_q  <= pend_q;
        last_q <= 1'b0;
      end
    end else if (cmd_i.flush && pend_v_q) begin
      out_q  <= pend_q;
      last_q <= 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      off_q    <= '0;
      nns_q    <= '0;
      nts_q    <= '0;
      old_q    <= '0;
      nns_m_q  <= '0;
      nts_m_q  <= '0;
      old_m_q  <= '0;
      fill_q   <= '0;
      guard_q  <= '0;
      timer_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        tail_q  <= ptr_inc(tail_q);
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.rewind) begin
        nts_q   <= old_q;
        nts_m_q <= old_m_q;
      end
      if (cmd_i.tstart) begin
        timer_q <= 1'b1;
      end
      if (cmd_i.tstop) begin
        timer_q <= 1'b0;
      end
      if (cmd_i.slide) begin
        fill_q  <= (d > 32'(fill_q)) ? '0 : fill_q - FW'(d);
        old_q   <= ack_q + 32'd1;
        old_m_q <= (msum >= 6'(WINDOW)) ? 4'(msum - 6'(WINDOW)) : msum[3:0];
      end
      // one build step
      if (cmd_i.build) begin
        if (rem > PM16) begin
          off_q   <= off_q + PM16;
          nns_q   <= nns_q + 32'd1;
          nns_m_q <= mod_inc(nns_m_q);
          fill_q  <= fill_q + 1'b1;
        end else begin
          if (rem != 16'd0) begin
            nns_q   <= nns_q + 32'd1;
            nns_m_q <= mod_inc(nns_m_q);
            fill_q  <= fill_q + 1'b1;
          end
          head_q  <= ptr_inc(head_q);
          count_q <= count_q - 1'b1;
          off_q   <= '0;
        end
      end
      if (cmd_i.send_init) begin
        guard_q <= '0;
      end
      if (cmd_i.send) begin
        nts_q   <= nts_q + 32'd1;
        nts_m_q <= mod_inc(nts_m_q);
        guard_q <= guard_q + 1'b1;
      end
      // pending and output word handoff
      if (emit_v) begin
        pend_v_q <= 1'b1;
        if (pend_v_q) begin
          out_v_q <= 1'b1;
        end else if (out_ready_i) begin
          out_v_q <= 1'b0;
        end
      end else if (cmd_i.flush && pend_v_q) begin
        pend_v_q <= 1'b0;
        out_v_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_res_o   = out_q;
  assign out_last_o  = last_q;
  assign out_valid_o = out_v_q;

endmodule
`default_nettype wire

// ----- design/go_back_n_sender_window.sv -----
// go_back_n_sender_window: top level of the go-back-n sender window control
// depends on gbn_pkg, gbn_ctrl and gbn_dpath
//
// Each input word is one protocol event (new message, ack, timer expiry) and
// yields a possibly empty run of command words (timer start/stop, build,
// send, overflow), the final one marked by tlast. Events are handled one at
// a time: the next word is taken once the previous event is finished. Each
// build step is one queue memory read and one cut; the sequencer walks build
// and send steps one by one. Output back-pressure stalls the sequencer.
// Results stay one word behind in a holding register so the last one can be
// flagged.
`default_nettype none
module go_back_n_sender_window #(
  parameter int unsigned WINDOW      = 10,
  parameter int unsigned PAYLOAD_MAX = 121,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // message_size[15:0], ack_number[47:16], checksum_ok[48], zero fill
  input  wire logic [55:0] s_axis_tdata,
  // operation[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // seq_number[31:0], window_slot[35:32], payload_length[43:36],
  // message_offset[59:44], message_end[60], zero fill
  output logic [63:0]      m_axis_tdata,
  // kind[2:0]
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast
);
  import gbn_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  res_t     res;

  gbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ck_i    (s_axis_tdata[48]),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gbn_dpath #(
    .WINDOW      (WINDOW),
    .PAYLOAD_MAX (PAYLOAD_MAX),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .size_i      (s_axis_tdata[15:0]),
    .ack_i       (s_axis_tdata[47:16]),
    .stat_o      (stat),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  // output word packing
  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {3'b000, res.message_end, res.message_offset,
                         res.payload_length, res.window_slot, res.seq_number};

endmodule
`default_nettype wire
